[rtl/core/pls_pkg.sv]
// Shared types and constants for the piecewise-linear schedule unit.
// No dependencies.
package pls_pkg;

    localparam int unsigned MaxPointsDef = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned ValW   = 32;
    localparam int unsigned StatW  = 2;

    localparam logic [StatW-1:0] StOk    = 2'd0;
    localparam logic [StatW-1:0] StEmpty = 2'd1;
    localparam logic [StatW-1:0] StFull  = 2'd2;

    localparam logic ReqSet   = 1'b0;
    localparam logic ReqQuery = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture the incoming word
        logic scan;      // compare entry at scan index, advance
        logic shift;     // move one entry up for insertion
        logic write;     // write new point at insert position
        logic overwrite; // replace value at matched position
        logic rd_pair;   // read neighbors for interpolation
        logic mul;       // form |diff|, its sign, span and dt
        logic div_init;  // form |diff| * dt, start divider
        logic div_step;  // one divider bit
        logic finish;    // drive result strobe
        logic [StatW-1:0] status;
        logic res_zero;  // result value forced to zero
        logic res_pick;  // result is a table value (no lerp)
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_query;
        logic empty;
        logic full;
        logic scan_done;  // scan reached stop point
        logic match;      // equal time found
        logic shift_done;
        logic div_done;
        logic pick;       // query answered by a table value
    } t_sts;

endpackage

[rtl/core/pls_datapath.sv]
// Datapath: breakpoint memories, scan pointer, multiplier and serial divider.
// Depends on pls_pkg.
module pls_datapath import pls_pkg::*; #(
    parameter int unsigned MAX_POINTS = MaxPointsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TimeW-1:0]      i_cfg_wdata,
    input  logic                  i_req_type,
    input  logic [TimeW-1:0]      i_timestep,
    input  logic signed [ValW-1:0] i_point_value,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_valid,
    output logic signed [ValW-1:0] o_value,
    output logic [StatW-1:0]      o_status
);
    localparam int unsigned IdxW = $clog2(MAX_POINTS);
    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
    localparam int unsigned DivW = 64;

    logic [TimeW-1:0] r_times  [MAX_POINTS];
    logic [ValW-1:0]  r_values [MAX_POINTS];

    logic [CntW-1:0]  r_count;
    logic [TimeW-1:0] r_offset;
    logic             r_query;
    logic [TimeW-1:0] r_t;
    logic [ValW-1:0]  r_v;
    logic [CntW-1:0]  r_pos, r_k;
    logic [TimeW-1:0] r_rt;     // registered read of times at r_pos
    logic [TimeW-1:0] r_ta, r_tb;
    logic signed [ValW-1:0] r_va, r_vb;
    logic [TimeW-1:0] r_mag;    // |vb-va| fits 32 bits
    logic             r_neg;
    logic [DivW-1:0]  r_num;
    logic [TimeW-1:0] r_den;
    logic [TimeW:0]   r_rem;
    logic [6:0]       r_bit;
    logic             r_valid;
    logic signed [ValW-1:0] r_value;
    logic [StatW-1:0] r_status;

    logic [CntW-1:0] n_pos;
    logic [IdxW-1:0] pos_i, km1_i, k_i;
    logic [TimeW-1:0] t_scan;
    logic [TimeW:0]   rem_sh;
    logic signed [ValW:0] diff;
    logic signed [ValW:0] res_w;

    assign pos_i = r_pos[IdxW-1:0];
    assign k_i   = r_k[IdxW-1:0];
    assign km1_i = IdxW'(r_k - CntW'(1));
    assign t_scan = r_rt;

    // scan pointer for the next cycle; the time read follows it
    always_comb begin
        if (i_cmd.load)      n_pos = '0;
        else if (i_cmd.scan) n_pos = r_pos + CntW'(1);
        else                 n_pos = r_pos;
    end

    // scan stop: set stops at first time >= t; query at first time > t
    always_comb begin
        o_sts.is_query  = r_query;
        o_sts.empty     = (r_count == '0);
        o_sts.full      = (r_count == CntW'(MAX_POINTS));
        o_sts.scan_done = (r_pos == r_count) ||
                          (r_query ? (t_scan > r_t) : (t_scan >= r_t));
        o_sts.match     = (r_pos != r_count) && (t_scan == r_t);
        o_sts.shift_done = (r_k == r_pos);
        o_sts.div_done  = (r_bit == '0);
        // query: before first, at/after last, or single point
        o_sts.pick      = (r_pos == '0) || (r_pos == r_count);
    end

    assign rem_sh = {r_rem[TimeW-1:0], r_num[DivW-1]};
    assign diff   = (ValW+1)'(r_vb) - (ValW+1)'(r_va);

    always_comb begin
        if (r_neg) res_w = (ValW+1)'(r_va) - (ValW+1)'(signed'({1'b0, r_num[ValW-1:0]}));
        else       res_w = (ValW+1)'(r_va) + (ValW+1)'(signed'({1'b0, r_num[ValW-1:0]}));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift && (r_k != r_pos)) begin
            r_times[k_i]  <= r_times[km1_i];
            r_values[k_i] <= r_values[km1_i];
        end
        if (i_cmd.write) begin
            r_times[pos_i]  <= r_t;
            r_values[pos_i] <= r_v;
        end
        if (i_cmd.overwrite) r_values[pos_i] <= r_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_offset <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cfg_we) r_offset <= i_cfg_wdata;
            if (i_cmd.write) r_count <= r_count + CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt <= r_times[IdxW'(n_pos)];
        if (i_cmd.load) begin
            r_query <= i_req_type;
            r_v     <= i_point_value;
            r_pos   <= '0;
            r_k     <= r_count;
            if (i_req_type == ReqQuery)
                r_t <= (i_timestep < r_offset) ? '0 : i_timestep - r_offset;
            else
                r_t <= i_timestep;
        end
        if (i_cmd.scan) begin
            r_pos <= r_pos + CntW'(1);
            r_k   <= r_count;
        end
        if (i_cmd.shift && (r_k != r_pos)) r_k <= r_k - CntW'(1);
        if (i_cmd.rd_pair) begin
            if (r_pos == '0) r_va <= r_values[0];
            else if (r_pos == r_count) r_va <= r_values[IdxW'(r_count - CntW'(1))];
            else begin
                r_va <= r_values[IdxW'(r_pos - CntW'(1))];
                r_ta <= r_times[IdxW'(r_pos - CntW'(1))];
            end
            r_vb <= r_values[pos_i];
            r_tb <= t_scan;
        end
        if (i_cmd.mul) begin
            r_neg <= diff[ValW];
            r_mag <= diff[ValW] ? TimeW'(-diff) : TimeW'(diff);
            r_den <= r_tb - r_ta;
            r_num <= DivW'(r_t - r_ta);
        end
        if (i_cmd.div_init) begin
            // 32 x 32 product, full 64-bit result
            r_num <= DivW'(r_mag) * DivW'(r_num[TimeW-1:0]);
            r_rem <= '0;
            r_bit <= 7'(DivW);
        end
        if (i_cmd.div_step) begin
            r_bit <= r_bit - 7'd1;
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sh - {1'b0, r_den};
                r_num <= {r_num[DivW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[DivW-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            if (i_cmd.res_zero)      r_value <= '0;
            else if (i_cmd.res_pick) r_value <= r_va;
            else                     r_value <= res_w[ValW-1:0];
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;
endmodule

[rtl/core/pls_ctrl.sv]
// Controller state machine sequencing scan, insert and interpolation.
// Depends on pls_pkg.
module pls_ctrl import pls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_SHIFT = 9'b000000100,
        S_PAIR  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DINIT = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.is_query && i_sts.empty) begin
                    o_cmd.finish = 1'b1; o_cmd.status = StEmpty; o_cmd.res_zero = 1'b1;
                    n_state = S_WAIT;
                end else if (!i_sts.scan_done) begin
                    o_cmd.scan = 1'b1;
                end else if (i_sts.is_query) begin
                    n_state = S_PAIR;
                end else if (i_sts.match) begin
                    o_cmd.overwrite = 1'b1; o_cmd.finish = 1'b1; o_cmd.res_zero = 1'b1;
                    n_state = S_WAIT;
                end else if (i_sts.full) begin
                    o_cmd.finish = 1'b1; o_cmd.status = StFull; o_cmd.res_zero = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.write = 1'b1; o_cmd.finish = 1'b1; o_cmd.res_zero = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_PAIR: begin
                o_cmd.rd_pair = 1'b1;
                n_state = i_sts.pick ? S_DONE : S_MUL;
            end
            S_MUL:   begin o_cmd.mul = 1'b1; n_state = S_DINIT; end
            S_DINIT: begin o_cmd.div_init = 1'b1; n_state = S_DIV; end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1; n_state = S_WAIT;
                end else o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1; o_cmd.res_pick = 1'b1; n_state = S_WAIT;
            end
            S_WAIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

[rtl/core/piecewise_linear_schedule_unit.sv]
// Top level of the piecewise-linear schedule unit: controller plus datapath.
// Depends on pls_pkg, pls_ctrl, pls_datapath.
//
//  channel | ports                                       | handshake
//  config  | i_cfg_we, i_cfg_wdata                       | write when i_cfg_we
//  request | i_start, o_busy, i_req_type, i_timestep,    | start & !busy
//          | i_point_value                               |
//  result  | o_done, o_value, o_status                   | one-cycle strobe
//
// An insert scans to the insert point, then shifts the tail one entry a cycle; an
// overwrite or a set refused as full ends after the scan. A query with interpolation
// runs the scan and the 64-step serial divider; a query answered by a table value
// skips the divider; a query on an empty table ends without a scan.
// Reset is synchronous and empties the table; time_offset returns to zero.
// One word in flight; o_busy holds until the result strobe has passed.
module piecewise_linear_schedule_unit import pls_pkg::*; #(
    parameter int unsigned MAX_POINTS = MaxPointsDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [TimeW-1:0]       i_cfg_wdata,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_req_type,
    input  logic [TimeW-1:0]       i_timestep,
    input  logic signed [ValW-1:0] i_point_value,
    output logic                   o_done,
    output logic signed [ValW-1:0] o_value,
    output logic [StatW-1:0]       o_status
);
    t_cmd cmd;
    t_sts sts;

    pls_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_sts(sts), .o_cmd(cmd), .o_busy
    );

    pls_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_req_type, .i_timestep,
        .i_point_value, .i_cmd(cmd), .o_sts(sts), .o_valid(o_done),
        .o_value, .o_status
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result strobe while idle");
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3)) else $error("bad status");
    a_set_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != StOk) |-> (o_value == '0)) else $error("nonzero on error");
endmodule

[tb/tb_piecewise_linear_schedule_unit.sv]
// Self-checking testbench for piecewise_linear_schedule_unit: breakpoint sets and
// interpolated queries checked against an in-bench table predictor.
// Depends on pls_pkg and the RTL of the unit.
module tb_piecewise_linear_schedule_unit;
    import pls_pkg::*;

    typedef struct packed {
        logic             req_type;
        logic [TimeW-1:0] timestep;
        logic [ValW-1:0]  point_value;
    } t_word;

    typedef struct packed {
        logic [ValW-1:0]  value;
        logic [StatW-1:0] status;
    } t_result;

    localparam int unsigned NPts = MaxPointsDef;
    localparam int unsigned CycleLimit = 400000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [TimeW-1:0]       i_cfg_wdata;
    logic                   i_start;
    logic                   o_busy;
    logic                   i_req_type;
    logic [TimeW-1:0]       i_timestep;
    logic signed [ValW-1:0] i_point_value;
    logic                   o_done;
    logic signed [ValW-1:0] o_value;
    logic [StatW-1:0]       o_status;

    piecewise_linear_schedule_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .o_busy(o_busy),
        .i_req_type(i_req_type), .i_timestep(i_timestep),
        .i_point_value(i_point_value),
        .o_done(o_done), .o_value(o_value), .o_status(o_status)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // predictor state
    logic [TimeW-1:0]       sched_t[NPts];
    logic signed [ValW-1:0] sched_v[NPts];
    int unsigned            sched_n;
    logic [TimeW-1:0]       offset_q;

    t_word   pending_words[$];
    t_result expected_results[$];
    int unsigned n_errors, n_sent, n_seen, n_queries, n_full, n_lerp, cycle_cnt;
    bit quiet_stretch;

    // busy as seen at the last rising edge, so acceptance is judged consistently
    logic o_busy_q;
    always @(posedge i_clk) begin
        o_busy_q <= o_busy;
    end

    function automatic logic signed [ValW-1:0] lerp_value(logic signed [ValW-1:0] va,
            logic signed [ValW-1:0] vb, logic [TimeW-1:0] dt, logic [TimeW-1:0] span);
        logic signed [63:0] diff;
        logic [63:0] mag, q;
        logic signed [63:0] r;
        diff = 64'(vb) - 64'(va);
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        q = (mag * 64'(dt)) / 64'(span);
        r = diff < 0 ? 64'(va) - $signed(q) : 64'(va) + $signed(q);
        return r[ValW-1:0];
    endfunction

    // updates the table on sets and returns the expected result word
    function automatic t_result schedule_step(t_word w);
        t_result res;
        int unsigned pos, k, i, last;
        logic [TimeW-1:0] t;
        res = '0;
        if (w.req_type == ReqSet) begin
            pos = 0;
            while (pos < sched_n && sched_t[pos] < w.timestep) pos++;
            if (pos < sched_n && sched_t[pos] == w.timestep) begin
                sched_v[pos] = w.point_value;
            end else if (sched_n >= NPts) begin
                res.status = StFull;
            end else begin
                for (k = sched_n; k > pos; k--) begin
                    sched_t[k] = sched_t[k-1];
                    sched_v[k] = sched_v[k-1];
                end
                sched_t[pos] = w.timestep;
                sched_v[pos] = w.point_value;
                sched_n++;
            end
        end else begin
            t = w.timestep < offset_q ? '0 : w.timestep - offset_q;
            last = sched_n - 1;
            if (sched_n == 0) res.status = StEmpty;
            else if (sched_n == 1 || t < sched_t[0]) res.value = sched_v[0];
            else if (t >= sched_t[last]) res.value = sched_v[last];
            else begin
                i = 1;
                while (i < last && sched_t[i] <= t) i++;
                res.value = lerp_value(sched_v[i-1], sched_v[i], t - sched_t[i-1],
                                       sched_t[i] - sched_t[i-1]);
                n_lerp++;
            end
        end
        return res;
    endfunction

    // driver: one word at a time, idles at random outside the quiet stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy_q) begin
            // accepted at the last rising edge; move on
            if (pending_words.size() > 0 && (quiet_stretch || $urandom_range(99) >= 28)) begin
                drive_word(pending_words.pop_front());
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start && pending_words.size() > 0 &&
                     (quiet_stretch || $urandom_range(99) >= 28)) begin
            drive_word(pending_words.pop_front());
        end
    end

    task automatic drive_word(t_word w);
        i_start       <= 1'b1;
        i_req_type    <= w.req_type;
        i_timestep    <= w.timestep;
        i_point_value <= w.point_value;
    endtask

    // monitor: predicts at acceptance, checks each strobe
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            cycle_cnt++;
            if (i_start && !o_busy) begin
                expected_results.push_back(schedule_step({i_req_type, i_timestep,
                                                          i_point_value}));
                n_sent++;
                if (i_req_type == ReqQuery) n_queries++;
            end
            if (o_done) begin
                got = {o_value, o_status};
                n_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word value=%h status=%0d", $time,
                             o_value, o_status);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status == StFull) n_full++;
                    if (got.value !== want.value) begin
                        $display("%0t: value mismatch expected %h actual %h", $time,
                                 want.value, got.value);
                        n_errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 want.status, got.status);
                        n_errors++;
                    end
                end
            end
        end
    end

    function automatic t_word mk(logic rt, logic [TimeW-1:0] ts, logic [ValW-1:0] pv);
        t_word w;
        w.req_type = rt;
        w.timestep = ts;
        w.point_value = pv;
        return w;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [TimeW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        offset_q = val;
    endtask

    function automatic logic [ValW-1:0] rand_val();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // a well-formed round: random breakpoint sets mixed with hard queries on the table
    task automatic random_round(int unsigned n_items, int unsigned tspan);
        int unsigned k;
        logic [TimeW-1:0] base;
        base = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1000));
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 35)
                pending_words.push_back(mk(ReqSet, base + $urandom_range(tspan), rand_val()));
            else if ($urandom_range(19) == 0)
                pending_words.push_back(mk(ReqQuery, $urandom, $urandom));
            else
                pending_words.push_back(mk(ReqQuery, base + offset_q +
                                           $urandom_range(tspan + 20) - 10, $urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_start = 1'b0;
        i_req_type = ReqSet;
        i_timestep = '0;
        i_point_value = '0;
        sched_n = 0;
        offset_q = '0;
        quiet_stretch = 1'b0;
        n_errors = 0; n_sent = 0; n_seen = 0; n_queries = 0; n_full = 0; n_lerp = 0;
        cycle_cnt = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty query, single point, extremes, overwrite, fill past full
        pending_words.push_back(mk(ReqQuery, 32'd0, 32'd0));
        pending_words.push_back(mk(ReqSet, 32'd100, 32'h7FFF_FFFF));
        pending_words.push_back(mk(ReqQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(mk(ReqSet, 32'hFFFF_FFFF, 32'h8000_0000));
        pending_words.push_back(mk(ReqQuery, 32'd0, 32'd0));
        pending_words.push_back(mk(ReqQuery, 32'h8000_0000, 32'd0));
        pending_words.push_back(mk(ReqQuery, 32'hFFFF_FFFF, 32'd0));
        pending_words.push_back(mk(ReqSet, 32'd100, 32'h0001_0000));
        pending_words.push_back(mk(ReqSet, 32'd0, 32'hFFFF_0000));
        pending_words.push_back(mk(ReqQuery, 32'd50, 32'd0));
        pending_words.push_back(mk(ReqQuery, 32'd100, 32'd0));
        for (int k = 0; k < 14; k++)
            pending_words.push_back(mk(ReqSet, 32'(200 + 37 * k), 32'(k * 32'h0003_1234)));
        pending_words.push_back(mk(ReqSet, 32'd5, 32'd7));
        pending_words.push_back(mk(ReqSet, 32'd237, 32'h8000_0000));
        pending_words.push_back(mk(ReqQuery, 32'd250, 32'd0));
        wait_drained();

        write_offset(32'hFFFF_FFFF);
        pending_words.push_back(mk(ReqQuery, 32'd1000, 32'd0));
        pending_words.push_back(mk(ReqQuery, 32'hFFFF_FFFF, 32'd0));
        wait_drained();
        write_offset(32'd150);
        pending_words.push_back(mk(ReqQuery, 32'd400, 32'd0));
        wait_drained();

        // random: a drain without reset cannot empty the table, so
        // rounds vary offset and span instead; a quiet stretch in the middle
        for (int r = 0; r < 12; r++) begin
            write_offset(r % 4 == 0 ? 32'd0 : (r % 4 == 1 ? 32'hFFFF_FFFF : $urandom_range(500)));
            quiet_stretch = (r == 5 || r == 6);
            random_round(50, r % 3 == 0 ? 32'hFFFF : 300);
            wait_drained();
        end
        quiet_stretch = 1'b0;

        $display("covered %0d words (%0d queries, %0d interpolated, %0d dropped on full)",
                 n_sent, n_queries, n_lerp, n_full);
        $display("%0d results checked, %0d mismatches", n_seen, n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/core/pls_pkg.sv
rtl/core/pls_datapath.sv
rtl/core/pls_ctrl.sv
rtl/core/piecewise_linear_schedule_unit.sv
tb/tb_piecewise_linear_schedule_unit.sv
